FILE: sv/ptcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcg_pkg: plasma tile color generator definitions
// Shared types, field widths and constants for the generator, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package ptcg_pkg;

    localparam int CMD_W     = 2;
    localparam int SEL_W     = 2;
    localparam int INDEX_W   = 8;
    localparam int VALUE_W   = 12;
    localparam int TILE_W    = 6;
    localparam int LEVEL_W   = 8;
    localparam int COLOR_W   = 12;
    localparam int WAVE_W    = 8;
    localparam int DEPTH     = 256;
    localparam int NUM_PHASE = 5;

    localparam int TILES_ACROSS = 36;
    localparam int TILES_DOWN   = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_TILE    = 2'd1,
        CMD_ADVANCE = 2'd2
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_WAVE_ONE   = 2'd0,
        SEL_WAVE_TWO   = 2'd1,
        SEL_WAVE_THREE = 2'd2,
        SEL_PALETTE    = 2'd3
    } sel_t;

    typedef logic [WAVE_W-1:0] phase_t;
    typedef phase_t [NUM_PHASE-1:0] phase_arr_t;

    // per-frame phase increments; the last one steps backward
    localparam phase_arr_t PHASE_STEP = '{8'hFF, 8'd1, 8'd2, 8'd3, 8'd1};

endpackage
`default_nettype wire

FILE: sv/ptcg_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcg_cmd_if: command channel
// Valid/ready channel carrying one table write, tile request or advance.
// ----------------------------------------------------------------------------
interface ptcg_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [ptcg_pkg::CMD_W-1:0]            command;
    logic [ptcg_pkg::SEL_W-1:0]            table_select;
    logic [ptcg_pkg::INDEX_W-1:0]          table_index;
    logic [ptcg_pkg::VALUE_W-1:0]          table_value;
    logic [ptcg_pkg::TILE_W-1:0]           tile_x;
    logic [ptcg_pkg::TILE_W-1:0]           tile_y;

    modport source (
        output valid, command, table_select, table_index, table_value, tile_x, tile_y,
        input  ready
    );

    modport sink (
        input  valid, command, table_select, table_index, table_value, tile_x, tile_y,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/ptcg_tile_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcg_tile_if: tile result channel
// Valid/ready channel carrying the level and palette color of one tile.
// ----------------------------------------------------------------------------
interface ptcg_tile_if;
    logic                                  valid;
    logic                                  ready;
    logic [ptcg_pkg::LEVEL_W-1:0]          tile_level;
    logic [ptcg_pkg::COLOR_W-1:0]          tile_color;

    modport source (
        output valid, tile_level, tile_color,
        input  ready
    );

    modport sink (
        input  valid, tile_level, tile_color,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/plasma_tile_color_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plasma_tile_color_generator: plasma level and color per tile
// Holds three wave tables and a color palette in synchronous memories and
// five frame phases in registers. Writes load table entries, advances step
// the phases, tile requests return the wrapped level and its palette color.
// ----------------------------------------------------------------------------
// Takes one command transaction per cycle unless stalled. A tile result passes
// through the lookup stage, the five wave table lookups (two read ports on
// tables one and two, one on table three), then the result stage, the sum
// of those lookups addressing the palette memory. Writes and advances take
// effect at once and are seen by every later tile request. Tiles outside the
// tile grid and the unused command code produce no result. The command side
// stalls only while both result stages are full and the tile side is not
// ready. Table entries read before they are written return unknown data.
// ----------------------------------------------------------------------------
module plasma_tile_color_generator #(
    parameter int TILES_ACROSS = ptcg_pkg::TILES_ACROSS,
    parameter int TILES_DOWN   = ptcg_pkg::TILES_DOWN
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ptcg_cmd_if.sink           cmd,
    ptcg_tile_if.source        tile
);

    localparam int IW = ptcg_pkg::INDEX_W;

    logic [ptcg_pkg::WAVE_W-1:0]  wave_one_mem   [ptcg_pkg::DEPTH];
    logic [ptcg_pkg::WAVE_W-1:0]  wave_two_mem   [ptcg_pkg::DEPTH];
    logic [ptcg_pkg::WAVE_W-1:0]  wave_three_mem [ptcg_pkg::DEPTH];
    logic [ptcg_pkg::COLOR_W-1:0] palette_mem    [ptcg_pkg::DEPTH];

    ptcg_pkg::phase_arr_t         phase_reg;

    logic                         lookup_valid_reg;
    logic                         result_valid_reg;
    logic [ptcg_pkg::WAVE_W-1:0]  one_x_reg;
    logic [ptcg_pkg::WAVE_W-1:0]  one_y_reg;
    logic [ptcg_pkg::WAVE_W-1:0]  two_x_reg;
    logic [ptcg_pkg::WAVE_W-1:0]  two_y_reg;
    logic [ptcg_pkg::WAVE_W-1:0]  three_x_reg;
    logic [ptcg_pkg::LEVEL_W-1:0] level_reg;
    logic [ptcg_pkg::COLOR_W-1:0] color_reg;

    logic                         result_en;
    logic                         lookup_en;
    logic                         accept;
    logic                         is_write;
    logic                         is_tile;
    logic                         is_advance;
    logic                         in_grid;
    logic [IW-1:0]                x8;
    logic [IW-1:0]                y8;
    logic [IW-1:0]                one_x_idx;
    logic [IW-1:0]                two_x_idx;
    logic [IW-1:0]                three_x_idx;
    logic [IW-1:0]                one_y_idx;
    logic [IW-1:0]                two_y_idx;
    logic [ptcg_pkg::LEVEL_W-1:0] level_sum;
    logic                         lookup_valid_next;
    logic                         result_valid_next;

    // handshake and stage enables
    assign result_en = !result_valid_reg || tile.ready;
    assign lookup_en = !lookup_valid_reg || result_en;
    assign cmd.ready = lookup_en;
    assign accept    = cmd.valid && lookup_en;

    always_comb
    begin
        is_write   = 1'b0;
        is_tile    = 1'b0;
        is_advance = 1'b0;
        case (cmd.command)
            ptcg_pkg::CMD_WRITE:   is_write   = 1'b1;
            ptcg_pkg::CMD_TILE:    is_tile    = 1'b1;
            ptcg_pkg::CMD_ADVANCE: is_advance = 1'b1;
            default:               ;
        endcase
    end

    assign in_grid = ({3'b000, cmd.tile_x} < 9'(TILES_ACROSS))
                  && ({3'b000, cmd.tile_y} < 9'(TILES_DOWN));

    // lookup addresses, all wrapping at the table depth
    assign x8          = {2'b00, cmd.tile_x};
    assign y8          = {2'b00, cmd.tile_y};
    assign one_x_idx   = phase_reg[0] + x8;
    assign two_x_idx   = phase_reg[1] + (x8 << 1);
    assign three_x_idx = phase_reg[2] + (x8 << 1) + x8;
    assign one_y_idx   = phase_reg[3] + (y8 << 1);
    assign two_y_idx   = phase_reg[4] + (y8 << 1) + y8;

    assign lookup_valid_next = lookup_en ? (accept && is_tile && in_grid) : lookup_valid_reg;
    assign result_valid_next = result_en ? lookup_valid_reg : result_valid_reg;

    // phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (accept && is_advance)
        begin
            for (int i = 0; i < ptcg_pkg::NUM_PHASE; i++)
            begin
                phase_reg[i] <= phase_reg[i] + ptcg_pkg::PHASE_STEP[i];
            end
        end
    end

    // wave table one: two read ports
    always_ff @(posedge clk)
    begin
        if (accept && is_write && cmd.table_select == ptcg_pkg::SEL_WAVE_ONE)
        begin
            wave_one_mem[cmd.table_index] <= cmd.table_value[ptcg_pkg::WAVE_W-1:0];
        end
        if (lookup_en)
        begin
            one_x_reg <= wave_one_mem[one_x_idx];
            one_y_reg <= wave_one_mem[one_y_idx];
        end
    end

    // wave table two: two read ports
    always_ff @(posedge clk)
    begin
        if (accept && is_write && cmd.table_select == ptcg_pkg::SEL_WAVE_TWO)
        begin
            wave_two_mem[cmd.table_index] <= cmd.table_value[ptcg_pkg::WAVE_W-1:0];
        end
        if (lookup_en)
        begin
            two_x_reg <= wave_two_mem[two_x_idx];
            two_y_reg <= wave_two_mem[two_y_idx];
        end
    end

    // wave table three
    always_ff @(posedge clk)
    begin
        if (accept && is_write && cmd.table_select == ptcg_pkg::SEL_WAVE_THREE)
        begin
            wave_three_mem[cmd.table_index] <= cmd.table_value[ptcg_pkg::WAVE_W-1:0];
        end
        if (lookup_en)
        begin
            three_x_reg <= wave_three_mem[three_x_idx];
        end
    end

    assign level_sum = one_x_reg + two_x_reg + three_x_reg + one_y_reg + two_y_reg;

    // palette: a write in the same cycle as the read belongs to a later transaction
    always_ff @(posedge clk)
    begin
        if (accept && is_write && cmd.table_select == ptcg_pkg::SEL_PALETTE)
        begin
            palette_mem[cmd.table_index] <= cmd.table_value;
        end
        if (result_en)
        begin
            color_reg <= palette_mem[level_sum];
            level_reg <= level_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            lookup_valid_reg <= lookup_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign tile.valid      = result_valid_reg;
    assign tile.tile_level = level_reg;
    assign tile.tile_color = color_reg;

endmodule
`default_nettype wire

FILE: sv/ptcg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcg_checker: port checks for the plasma tile color generator
// Watches the command and tile channels and flags ordering and flow errors.
// ----------------------------------------------------------------------------
module ptcg_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    input  wire logic                           cmd_ready,
    input  wire logic [ptcg_pkg::CMD_W-1:0]     cmd_command,
    input  wire logic                           tile_valid,
    input  wire logic                           tile_ready,
    input  wire logic [ptcg_pkg::LEVEL_W-1:0]   tile_level,
    input  wire logic [ptcg_pkg::COLOR_W-1:0]   tile_color
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && !tile_ready |=> tile_valid && $stable(tile_level) && $stable(tile_color))
        else $error("tile result changed while stalled");

    // a new result follows an accepted tile request through the lookup and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tile_valid) |->
            $past(cmd_valid && cmd_ready && cmd_command == ptcg_pkg::CMD_TILE, 2))
        else $error("tile result without a matching request");

    // an empty result stage never blocks commands
    assert property (@(posedge clk) disable iff (!rst_n)
        !tile_valid |-> cmd_ready)
        else $error("command stalled with empty result stage");

    // commands stall only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> tile_valid && !tile_ready)
        else $error("command stalled without back pressure");

endmodule

bind plasma_tile_color_generator ptcg_checker u_ptcg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.command),
    .tile_valid  (tile.valid),
    .tile_ready  (tile.ready),
    .tile_level  (tile.tile_level),
    .tile_color  (tile.tile_color)
);
`default_nettype wire

FILE: tb/sv/plasma_tile_color_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plasma_tile_color_generator_test: self-checking bench for the tile generator
// Feeds table writes, frame advances, tile requests and unused commands through the command
// channel with random gaps, predicts each tile level and color from a
// shadow copy of the tables and phases, and compares every tile result in
// order. Tile requests only touch entries that were written before.
// ----------------------------------------------------------------------------
module plasma_tile_color_generator_test;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 10;
    localparam int          ITEM_TARGET  = 750;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          SETTLE       = 10;
    localparam int unsigned RUN_LIMIT    = 500000;

    localparam logic [ptcg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef logic [ptcg_pkg::DEPTH-1:0][ptcg_pkg::WAVE_W-1:0] wave_tab_t;

    typedef struct packed {
        wave_tab_t [2:0]                                    wave;
        logic [ptcg_pkg::DEPTH-1:0][ptcg_pkg::COLOR_W-1:0] palette;
        ptcg_pkg::phase_arr_t                               phase;
    } plasma_state_t;

    typedef struct packed {
        logic [ptcg_pkg::CMD_W-1:0]   command;
        logic [ptcg_pkg::SEL_W-1:0]   table_select;
        logic [ptcg_pkg::INDEX_W-1:0] table_index;
        logic [ptcg_pkg::VALUE_W-1:0] table_value;
        logic [ptcg_pkg::TILE_W-1:0]  tile_x;
        logic [ptcg_pkg::TILE_W-1:0]  tile_y;
        logic [4:0]                   gap;
        logic                         drain;
    } plasma_cmd_t;

    typedef struct packed {
        logic [ptcg_pkg::LEVEL_W-1:0] level;
        logic [ptcg_pkg::COLOR_W-1:0] color;
    } tile_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ptcg_cmd_if  cmd ();
    ptcg_tile_if tile ();

    plasma_tile_color_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .tile  (tile)
    );

    plasma_cmd_t   cmd_backlog[$];
    tile_result_t  expected_tiles[$];
    plasma_state_t shadow_state;
    plasma_state_t plan_state;
    bit [3:0][ptcg_pkg::DEPTH-1:0] plan_written;
    plasma_cmd_t   offered_cmd;

    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned rx_run_left;
    int unsigned hold_left;
    int unsigned planned_items;
    int unsigned cycle_count = 0;
    int          cmd_seen;
    int          hold_at = -1;
    int          failures = 0;
    bit          rx_calm;
    bit          tx_calm;
    bit          pause_next;

    always #CLK_HALF clk = ~clk;

    function automatic logic [ptcg_pkg::INDEX_W-1:0] lookup_index(
        plasma_state_t s, int term,
        logic [ptcg_pkg::TILE_W-1:0] x,
        logic [ptcg_pkg::TILE_W-1:0] y);
        logic [ptcg_pkg::INDEX_W-1:0] xi;
        logic [ptcg_pkg::INDEX_W-1:0] yi;
        xi = ptcg_pkg::INDEX_W'(x);
        yi = ptcg_pkg::INDEX_W'(y);
        case (term)
            0:       return s.phase[0] + xi;
            1:       return s.phase[1] + xi + xi;
            2:       return s.phase[2] + xi + xi + xi;
            3:       return s.phase[3] + yi + yi;
            default: return s.phase[4] + yi + yi + yi;
        endcase
    endfunction

    // terms 0..4 read tables one, two, three, one, two
    function automatic logic [ptcg_pkg::LEVEL_W-1:0] plasma_level(
        plasma_state_t s,
        logic [ptcg_pkg::TILE_W-1:0] x,
        logic [ptcg_pkg::TILE_W-1:0] y);
        logic [ptcg_pkg::LEVEL_W-1:0] sum;
        sum = '0;
        for (int t = 0; t < ptcg_pkg::NUM_PHASE; t++)
            sum = sum + s.wave[t % 3][lookup_index(s, t, x, y)];
        return sum;
    endfunction

    function automatic plasma_state_t apply_command(plasma_state_t s, plasma_cmd_t c);
        if (c.command == ptcg_pkg::CMD_WRITE)
        begin
            if (c.table_select == ptcg_pkg::SEL_PALETTE)
                s.palette[c.table_index] = c.table_value;
            else
                s.wave[c.table_select][c.table_index] =
                    c.table_value[ptcg_pkg::WAVE_W-1:0];
        end
        else if (c.command == ptcg_pkg::CMD_ADVANCE)
        begin
            for (int k = 0; k < ptcg_pkg::NUM_PHASE; k++)
                s.phase[k] = s.phase[k] + ptcg_pkg::PHASE_STEP[k];
        end
        return s;
    endfunction

    function automatic plasma_cmd_t random_cmd();
        plasma_cmd_t c;
        c.command      = ptcg_pkg::CMD_W'($urandom_range(0, 3));
        c.table_select = ptcg_pkg::SEL_W'($urandom_range(0, 3));
        c.table_index  = ptcg_pkg::INDEX_W'($urandom_range(0, ptcg_pkg::DEPTH - 1));
        c.table_value  = ptcg_pkg::VALUE_W'($urandom_range(0, 4095));
        c.tile_x       = ptcg_pkg::TILE_W'($urandom_range(0, 63));
        c.tile_y       = ptcg_pkg::TILE_W'($urandom_range(0, 63));
        c.gap          = '0;
        c.drain        = 1'b0;
        return c;
    endfunction

    task automatic queue_cmd(plasma_cmd_t c);
        c.gap   = tx_calm ? 5'd0 : 5'($urandom_range(0, 17));
        c.drain = pause_next;
        pause_next = 1'b0;
        if (c.command == ptcg_pkg::CMD_WRITE)
            plan_written[c.table_select][c.table_index] = 1'b1;
        planned_items++;
        plan_state = apply_command(plan_state, c);
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_write(logic [ptcg_pkg::SEL_W-1:0] sel,
                               logic [ptcg_pkg::INDEX_W-1:0] idx,
                               logic [ptcg_pkg::VALUE_W-1:0] value);
        plasma_cmd_t c;
        c = random_cmd();
        c.command      = ptcg_pkg::CMD_WRITE;
        c.table_select = sel;
        c.table_index  = idx;
        c.table_value  = value;
        queue_cmd(c);
    endtask

    // fill any unwritten entry the request would read, then request
    task automatic queue_tile(logic [ptcg_pkg::TILE_W-1:0] x,
                              logic [ptcg_pkg::TILE_W-1:0] y);
        plasma_cmd_t                  c;
        logic [ptcg_pkg::INDEX_W-1:0] idx;
        logic [ptcg_pkg::LEVEL_W-1:0] lvl;
        if (x < ptcg_pkg::TILES_ACROSS && y < ptcg_pkg::TILES_DOWN)
        begin
            for (int t = 0; t < ptcg_pkg::NUM_PHASE; t++)
            begin
                idx = lookup_index(plan_state, t, x, y);
                if (!plan_written[t % 3][idx])
                    queue_write(ptcg_pkg::SEL_W'(t % 3), idx,
                                ptcg_pkg::VALUE_W'($urandom_range(0, 4095)));
            end
            lvl = plasma_level(plan_state, x, y);
            if (!plan_written[ptcg_pkg::SEL_PALETTE][lvl])
                queue_write(ptcg_pkg::SEL_PALETTE, lvl,
                            ptcg_pkg::VALUE_W'($urandom_range(0, 4095)));
        end
        c = random_cmd();
        c.command = ptcg_pkg::CMD_TILE;
        c.tile_x  = x;
        c.tile_y  = y;
        queue_cmd(c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : tx_side
        tile_result_t want;
        if (!rst_n)
        begin
            cmd.valid        <= 1'b0;
            cmd.command      <= '0;
            cmd.table_select <= '0;
            cmd.table_index  <= '0;
            cmd.table_value  <= '0;
            cmd.tile_x       <= '0;
            cmd.tile_y       <= '0;
            shadow_state = '0;
            idle_left    = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                if (offered_cmd.command == ptcg_pkg::CMD_TILE &&
                    offered_cmd.tile_x < ptcg_pkg::TILES_ACROSS &&
                    offered_cmd.tile_y < ptcg_pkg::TILES_DOWN)
                begin
                    want.level = plasma_level(shadow_state, offered_cmd.tile_x,
                                              offered_cmd.tile_y);
                    want.color = shadow_state.palette[want.level];
                    expected_tiles.push_back(want);
                end
                shadow_state = apply_command(shadow_state, offered_cmd);
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (cmd_backlog.size() == 0)
                    cmd.valid <= 1'b0;
                else if (idle_left != 0)
                begin
                    idle_left = idle_left - 1;
                    cmd.valid <= 1'b0;
                end
                else if (cmd_backlog[0].drain && expected_tiles.size() != 0)
                    cmd.valid <= 1'b0;
                else
                begin
                    offered_cmd = cmd_backlog.pop_front();
                    cmd.valid        <= 1'b1;
                    cmd.command      <= offered_cmd.command;
                    cmd.table_select <= offered_cmd.table_select;
                    cmd.table_index  <= offered_cmd.table_index;
                    cmd.table_value  <= offered_cmd.table_value;
                    cmd.tile_x       <= offered_cmd.tile_x;
                    cmd.tile_y       <= offered_cmd.tile_y;
                    idle_left = (cmd_backlog.size() != 0) ? cmd_backlog[0].gap : 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            cmd_seen  <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                cmd_seen <= cmd_seen + 1;
            if (cmd.valid && cmd.ready && cmd_seen == hold_at)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : rx_side
        tile_result_t want;
        if (!rst_n)
        begin
            tile.ready <= 1'b0;
            stall_left  = 0;
            rx_run_left = 0;
            rx_calm     = 1'b0;
        end
        else
        begin
            if (tile.valid && tile.ready)
            begin
                if (expected_tiles.size() == 0)
                begin
                    $error("unexpected tile transaction: tile_level %0d tile_color %0h",
                           tile.tile_level, tile.tile_color);
                    failures++;
                end
                else
                begin
                    want = expected_tiles.pop_front();
                    if (tile.tile_level !== want.level)
                    begin
                        $error("tile_level mismatch: expected %0d, actual %0d",
                               want.level, tile.tile_level);
                        failures++;
                    end
                    if (tile.tile_color !== want.color)
                    begin
                        $error("tile_color mismatch: expected %0h, actual %0h",
                               want.color, tile.tile_color);
                        failures++;
                    end
                end
                if (rx_run_left == 0)
                begin
                    rx_run_left = $urandom_range(10, 60);
                    rx_calm     = ($urandom_range(0, 2) == 0);
                end
                rx_run_left = rx_run_left - 1;
                stall_left  = rx_calm ? 0 : $urandom_range(0, 17);
            end
            if (stall_left != 0 || hold_left != 0)
            begin
                tile.ready <= 1'b0;
                if (stall_left != 0)
                    stall_left = stall_left - 1;
            end
            else
                tile.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        plasma_cmd_t c;
        int          pick;
        int          step;
        rst_n = 1'b0;
        plan_state    = '0;
        plan_written  = '0;
        planned_items = 0;
        tx_calm       = 1'b0;
        pause_next    = 1'b0;

        for (int s = 0; s < 4; s++)
        begin
            queue_write(ptcg_pkg::SEL_W'(s), 8'h00, 12'hFFF);
            queue_write(ptcg_pkg::SEL_W'(s), 8'hFF, 12'h000);
        end
        queue_tile(6'd0, 6'd0);
        queue_tile(ptcg_pkg::TILE_W'(ptcg_pkg::TILES_ACROSS - 1),
                   ptcg_pkg::TILE_W'(ptcg_pkg::TILES_DOWN - 1));
        queue_tile(ptcg_pkg::TILE_W'(ptcg_pkg::TILES_ACROSS), 6'd5);
        queue_tile(6'd63, 6'd0);
        c = random_cmd();
        c.command = CMD_UNUSED;
        queue_cmd(c);
        for (int k = 0; k < 2; k++)
        begin
            c = random_cmd();
            c.command = ptcg_pkg::CMD_ADVANCE;
            queue_cmd(c);
        end
        queue_tile(6'd0, 6'd0);
        queue_tile(6'd0, ptcg_pkg::TILE_W'(ptcg_pkg::TILES_DOWN - 1));

        pause_next = 1'b1;
        step = 0;
        while (planned_items < ITEM_TARGET)
        begin
            if (step % 40 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (step == 300)
            begin
                hold_at = cmd_backlog.size();
                tx_calm = 1'b1;
                for (int b = 0; b < 30; b++)
                    queue_tile(
                        ptcg_pkg::TILE_W'($urandom_range(0, ptcg_pkg::TILES_ACROSS - 1)),
                        ptcg_pkg::TILE_W'($urandom_range(0, 63)));
                tx_calm = 1'b0;
            end
            if ($urandom_range(0, 99) == 0)
                pause_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_tile(
                    ptcg_pkg::TILE_W'($urandom_range(0, ptcg_pkg::TILES_ACROSS - 1)),
                    ptcg_pkg::TILE_W'($urandom_range(0, 63)));
            else if (pick < 70)
                queue_write(ptcg_pkg::SEL_W'($urandom_range(0, 3)),
                            ptcg_pkg::INDEX_W'($urandom_range(0, ptcg_pkg::DEPTH - 1)),
                            ptcg_pkg::VALUE_W'($urandom_range(0, 4095)));
            else if (pick < 80)
            begin
                c = random_cmd();
                c.command = ptcg_pkg::CMD_ADVANCE;
                queue_cmd(c);
            end
            else if (pick < 92)
                queue_tile(
                    ptcg_pkg::TILE_W'($urandom_range(ptcg_pkg::TILES_ACROSS, 63)),
                    ptcg_pkg::TILE_W'($urandom_range(0, 63)));
            else
            begin
                c = random_cmd();
                c.command = CMD_UNUSED;
                queue_cmd(c);
            end
            step++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd.valid || expected_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
sv/ptcg_pkg.sv
sv/ptcg_cmd_if.sv
sv/ptcg_tile_if.sv
sv/plasma_tile_color_generator.sv
sv/ptcg_checker.sv
tb/sv/plasma_tile_color_generator_test.sv
